[rtl/disk_adapter_registers_top_defines.svh]
// Assertion macros shared by the disk adapter register block.
// Expects clk and rst_n in the scope of each use.
`ifndef DISK_ADAPTER_REGISTERS_TOP_DEFINES_SVH
`define DISK_ADAPTER_REGISTERS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DAR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DAR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dar_pkg.sv]
// Types, codes and constants of the disk adapter register block.
// No dependencies; used by every module of the block.
`default_nettype none

package dar_pkg;

    // Default sizes
    localparam int SIDE_BYTES_DEF = 65536;
    localparam int SEEK_DELAY_DEF = 150;

    // Item operations
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    // Register indexes (address minus 0x4020)
    localparam logic [4:0] REG_RELOAD_LO  = 5'd0;
    localparam logic [4:0] REG_RELOAD_HI  = 5'd1;
    localparam logic [4:0] REG_TIMER_CTRL = 5'd2;
    localparam logic [4:0] REG_IO_ENABLE  = 5'd3;
    localparam logic [4:0] REG_DATA_WR    = 5'd4;
    localparam logic [4:0] REG_DISK_CTRL  = 5'd5;
    localparam logic [4:0] REG_STATUS     = 5'd16;
    localparam logic [4:0] REG_DATA_RD    = 5'd17;
    localparam logic [4:0] REG_DRIVE_STAT = 5'd18;
    localparam logic [4:0] REG_EXT_PORT   = 5'd19;

    // Block kinds of the transfer sequencer
    localparam logic [2:0] BLK_INIT   = 3'd0;
    localparam logic [2:0] BLK_VOLUME = 3'd1;
    localparam logic [2:0] BLK_COUNT  = 3'd2;
    localparam logic [2:0] BLK_HEADER = 3'd3;
    localparam logic [2:0] BLK_DATA   = 3'd4;

    // Block lengths
    localparam logic [15:0] LEN_VOLUME = 16'h0038;
    localparam logic [15:0] LEN_COUNT  = 16'h0002;
    localparam logic [15:0] LEN_HEADER = 16'h0010;

    // Header offsets of the file size bytes
    localparam logic [15:0] OFS_SIZE_LO = 16'd13;
    localparam logic [15:0] OFS_SIZE_HI = 16'd14;

    // Control register bits
    localparam int CTL_MOTOR  = 0;
    localparam int CTL_RESET  = 1;
    localparam int CTL_READ   = 2;
    localparam int CTL_MIRROR = 3;
    localparam int CTL_XFER   = 6;
    localparam int CTL_IRQ_EN = 7;

    // Fixed read values
    localparam logic [7:0] STAT_BASE  = 8'h80;
    localparam logic [7:0] DRIVE_BASE = 8'h40;
    localparam logic [7:0] EXT_VALUE  = 8'h80;
    localparam logic [7:0] BYTE_END   = 8'hFF;

    typedef struct packed {
        op_t         op;
        logic [4:0]  reg_index;
        logic [7:0]  write_data;
        logic [15:0] image_address;
        logic [7:0]  elapsed_cycles;
        logic        disk_present;
        logic [7:0]  open_bus;
    } item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       disk_irq;
        logic       mirror_horizontal;
    } result_t;

    // Item state after the register stage, waiting for store data
    typedef struct packed {
        logic [7:0] read_data;
        logic       mem_rd;
        logic       cap_en;
        logic       cap_hi;
        logic       timer_irq;
        logic       disk_irq;
        logic       mirror;
    } stage_t;

    // Store access; addr already reduced into the side
    typedef struct packed {
        logic        we;
        logic        re;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // File size capture from a store read, fed back to the register stage
    typedef struct packed {
        logic       en;
        logic       hi;
        logic [7:0] data;
    } cap_t;

endpackage

`default_nettype wire

[rtl/dar_store.sv]
// Byte store of one disk side: one write or one read per cycle, registered read.
// Depends on dar_pkg for the access request type.
`default_nettype none

module dar_store #(
    parameter int SIDE_BYTES = dar_pkg::SIDE_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire dar_pkg::mem_req_t req,
    output logic [7:0]             rdata
);
    import dar_pkg::*;

    localparam int AW = $clog2(SIDE_BYTES);

    logic [7:0] mem [SIDE_BYTES];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[AW-1:0]] <= req.wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.addr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/dar_ctrl.sv]
// Register stage: timer, seek countdown, transfer sequencer and store requests.
// Depends on dar_pkg; drives dar_store and feeds dar_pipe.
`default_nettype none

module dar_ctrl #(
    parameter int SIDE_BYTES = dar_pkg::SIDE_BYTES_DEF,
    parameter int SEEK_DELAY = dar_pkg::SEEK_DELAY_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire dar_pkg::item_t    item,
    input  wire dar_pkg::cap_t     cap,
    output dar_pkg::stage_t        stage,
    output dar_pkg::mem_req_t      req
);
    import dar_pkg::*;

    localparam int SW = $clog2(SEEK_DELAY + 1);
    localparam logic [SW-1:0] SEEK_LOAD = SW'(SEEK_DELAY);
    localparam logic [23:0]   SIDE_W    = 24'(SIDE_BYTES);

    // Address reduction into the side; quotient fits 8 bits as the side is >= 256
    function automatic logic [15:0] store_pos(input logic [15:0] a);
        logic [23:0] r;
        r = {8'd0, a};
        for (int i = 7; i >= 0; i--)
        begin
            if (r >= (SIDE_W << i))
            begin
                r = r - (SIDE_W << i);
            end
        end
        return r[15:0];
    endfunction

    logic [15:0]   timer_reload_reg, timer_reload_next;
    logic [15:0]   timer_count_reg, timer_count_next;
    logic          timer_enabled_reg, timer_enabled_next;
    logic          timer_repeat_reg, timer_repeat_next;
    logic          io_enabled_reg, io_enabled_next;
    logic [SW-1:0] seek_count_reg, seek_count_next;
    logic [7:0]    control_reg, control_next;
    logic [15:0]   file_size_reg, file_size_next;
    logic [2:0]    block_kind_reg, block_kind_next;
    logic [15:0]   block_base_reg, block_base_next;
    logic [15:0]   block_length_reg, block_length_next;
    logic [15:0]   block_offset_reg, block_offset_next;
    logic          accessed_reg, accessed_next;
    logic          timer_pending_reg, timer_pending_next;
    logic          disk_pending_reg, disk_pending_next;

    logic [15:0] fs_fwd;
    logic [15:0] blk_pos;
    logic        in_block;
    logic        at_size_lo;
    logic        at_size_hi;
    logic [2:0]  kind_inc;
    logic [7:0]  v;
    logic [8:0]  cyc_w;
    logic [8:0]  seek_w;

    // File size as left by a store read now leaving the read stage
    always_comb
    begin
        fs_fwd = file_size_reg;
        if (cap.en)
        begin
            if (cap.hi)
            begin
                fs_fwd = file_size_reg | {cap.data, 8'h00};
            end
            else
            begin
                fs_fwd = {8'h00, cap.data};
            end
        end
    end

    assign blk_pos    = store_pos(block_base_reg + block_offset_reg);
    assign in_block   = block_offset_reg < block_length_reg;
    assign at_size_lo = (block_kind_reg == BLK_HEADER) && (block_offset_reg == OFS_SIZE_LO);
    assign at_size_hi = (block_kind_reg == BLK_HEADER) && (block_offset_reg == OFS_SIZE_HI);
    assign kind_inc   = (block_kind_reg >= BLK_DATA) ? BLK_HEADER : block_kind_reg + 3'd1;
    assign v          = item.write_data;
    // Seek compare runs wide enough for the full 8-bit elapsed count
    assign cyc_w      = {1'b0, item.elapsed_cycles};
    assign seek_w     = 9'(seek_count_reg);

    // Per-item update
    always_comb
    begin
        timer_reload_next  = timer_reload_reg;
        timer_count_next   = timer_count_reg;
        timer_enabled_next = timer_enabled_reg;
        timer_repeat_next  = timer_repeat_reg;
        io_enabled_next    = io_enabled_reg;
        seek_count_next    = seek_count_reg;
        control_next       = control_reg;
        file_size_next     = fs_fwd;
        block_kind_next    = block_kind_reg;
        block_base_next    = block_base_reg;
        block_length_next  = block_length_reg;
        block_offset_next  = block_offset_reg;
        accessed_next      = accessed_reg;
        timer_pending_next = timer_pending_reg;
        disk_pending_next  = disk_pending_reg;

        stage.read_data = 8'h00;
        stage.mem_rd    = 1'b0;
        stage.cap_en    = 1'b0;
        stage.cap_hi    = 1'b0;

        req.we    = 1'b0;
        req.re    = 1'b0;
        req.addr  = blk_pos;
        req.wdata = v;

        if (accept)
        begin
            case (item.op)
                OP_TICK:
                begin
                    // Reload timer
                    if (timer_enabled_reg && (timer_count_reg != 16'd0))
                    begin
                        if (timer_count_reg <= {8'd0, item.elapsed_cycles})
                        begin
                            timer_pending_next = 1'b1;
                            if (timer_repeat_reg)
                            begin
                                timer_count_next = timer_reload_reg;
                            end
                            else
                            begin
                                timer_enabled_next = 1'b0;
                                timer_count_next   = 16'd0;
                            end
                        end
                        else
                        begin
                            timer_count_next = timer_count_reg - {8'd0, item.elapsed_cycles};
                        end
                    end
                    // Seek countdown
                    if (seek_count_reg != '0)
                    begin
                        if (seek_w <= cyc_w)
                        begin
                            seek_count_next = '0;
                            if (control_reg[CTL_IRQ_EN])
                            begin
                                disk_pending_next = 1'b1;
                            end
                        end
                        else
                        begin
                            seek_count_next = SW'(seek_w - cyc_w);
                        end
                    end
                end

                OP_READ:
                begin
                    if (io_enabled_reg)
                    begin
                        case (item.reg_index)
                            REG_STATUS:
                            begin
                                stage.read_data = STAT_BASE
                                                | {6'd0, disk_pending_reg, timer_pending_reg};
                                timer_pending_next = 1'b0;
                                disk_pending_next  = 1'b0;
                            end
                            REG_DATA_RD:
                            begin
                                stage.read_data = BYTE_END;
                                if (item.disk_present && control_reg[CTL_READ])
                                begin
                                    accessed_next = 1'b1;
                                    if (in_block)
                                    begin
                                        req.re            = 1'b1;
                                        stage.mem_rd      = 1'b1;
                                        stage.cap_en      = at_size_lo || at_size_hi;
                                        stage.cap_hi      = at_size_hi;
                                        block_offset_next = block_offset_reg + 16'd1;
                                    end
                                    seek_count_next   = SEEK_LOAD;
                                    disk_pending_next = 1'b0;
                                end
                            end
                            REG_DRIVE_STAT:
                            begin
                                stage.read_data = DRIVE_BASE;
                                if (!item.disk_present)
                                begin
                                    stage.read_data = stage.read_data | 8'h05;
                                end
                                if (!item.disk_present || !control_reg[CTL_MOTOR]
                                    || control_reg[CTL_RESET])
                                begin
                                    stage.read_data = stage.read_data | 8'h02;
                                end
                            end
                            REG_EXT_PORT:
                            begin
                                stage.read_data = EXT_VALUE;
                            end
                            default:
                            begin
                                stage.read_data = item.open_bus;
                            end
                        endcase
                    end
                end

                OP_WRITE:
                begin
                    case (item.reg_index)
                        REG_RELOAD_LO:
                        begin
                            timer_reload_next = {timer_reload_reg[15:8], v};
                        end
                        REG_RELOAD_HI:
                        begin
                            timer_reload_next = {v, timer_reload_reg[7:0]};
                        end
                        REG_TIMER_CTRL:
                        begin
                            timer_repeat_next  = v[0];
                            timer_enabled_next = io_enabled_reg && v[1];
                            if (io_enabled_reg && v[1])
                            begin
                                timer_count_next = timer_reload_reg;
                            end
                            else
                            begin
                                timer_pending_next = 1'b0;
                            end
                        end
                        REG_IO_ENABLE:
                        begin
                            io_enabled_next = v[0];
                            if (!v[0])
                            begin
                                timer_enabled_next = 1'b0;
                                timer_pending_next = 1'b0;
                                disk_pending_next  = 1'b0;
                            end
                        end
                        REG_DATA_WR:
                        begin
                            if (io_enabled_reg && item.disk_present && !control_reg[CTL_READ])
                            begin
                                if (!accessed_reg)
                                begin
                                    accessed_next = 1'b1;
                                end
                                else if (in_block)
                                begin
                                    req.we = 1'b1;
                                    if (at_size_lo)
                                    begin
                                        file_size_next = {8'h00, v};
                                    end
                                    else if (at_size_hi)
                                    begin
                                        file_size_next = fs_fwd | {v, 8'h00};
                                    end
                                    block_offset_next = block_offset_reg + 16'd1;
                                end
                            end
                        end
                        REG_DISK_CTRL:
                        begin
                            if (io_enabled_reg)
                            begin
                                if (item.disk_present)
                                begin
                                    // Start of the next block
                                    if (v[CTL_XFER] && !control_reg[CTL_XFER])
                                    begin
                                        accessed_next     = 1'b0;
                                        block_base_next   = block_base_reg + block_offset_reg;
                                        block_offset_next = 16'd0;
                                        block_kind_next   = kind_inc;
                                        case (kind_inc)
                                            BLK_VOLUME: block_length_next = LEN_VOLUME;
                                            BLK_COUNT:  block_length_next = LEN_COUNT;
                                            BLK_HEADER: block_length_next = LEN_HEADER;
                                            default:    block_length_next = fs_fwd + 16'd1;
                                        endcase
                                    end
                                    // Sequencer reset
                                    if (v[CTL_RESET])
                                    begin
                                        block_kind_next   = BLK_INIT;
                                        block_base_next   = 16'd0;
                                        block_length_next = 16'd0;
                                        block_offset_next = 16'd0;
                                    end
                                    if (v[CTL_RESET] || v[CTL_XFER])
                                    begin
                                        seek_count_next = SEEK_LOAD;
                                    end
                                end
                                disk_pending_next = 1'b0;
                                control_next      = v;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                OP_LOAD:
                begin
                    req.we   = 1'b1;
                    req.addr = store_pos(item.image_address);
                end

                default:
                begin
                end
            endcase
        end

        stage.timer_irq = timer_pending_next;
        stage.disk_irq  = disk_pending_next;
        stage.mirror    = control_next[CTL_MIRROR];
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reload_reg  <= 16'd0;
            timer_count_reg   <= 16'd0;
            timer_enabled_reg <= 1'b0;
            timer_repeat_reg  <= 1'b0;
            io_enabled_reg    <= 1'b0;
            seek_count_reg    <= '0;
            control_reg       <= 8'd0;
            file_size_reg     <= 16'd0;
            block_kind_reg    <= BLK_INIT;
            block_base_reg    <= 16'd0;
            block_length_reg  <= 16'd0;
            block_offset_reg  <= 16'd0;
            accessed_reg      <= 1'b0;
            timer_pending_reg <= 1'b0;
            disk_pending_reg  <= 1'b0;
        end
        else
        begin
            timer_reload_reg  <= timer_reload_next;
            timer_count_reg   <= timer_count_next;
            timer_enabled_reg <= timer_enabled_next;
            timer_repeat_reg  <= timer_repeat_next;
            io_enabled_reg    <= io_enabled_next;
            seek_count_reg    <= seek_count_next;
            control_reg       <= control_next;
            file_size_reg     <= file_size_next;
            block_kind_reg    <= block_kind_next;
            block_base_reg    <= block_base_next;
            block_length_reg  <= block_length_next;
            block_offset_reg  <= block_offset_next;
            accessed_reg      <= accessed_next;
            timer_pending_reg <= timer_pending_next;
            disk_pending_reg  <= disk_pending_next;
        end
    end

endmodule

`default_nettype wire

[rtl/dar_pipe.sv]
// Read stage and output register: merges store data into the result.
// Depends on dar_pkg and the assertion macros header.
`default_nettype none
`include "disk_adapter_registers_top_defines.svh"

module dar_pipe (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire dar_pkg::stage_t  stage,
    input  wire logic [7:0]       rdata,
    input  wire logic             result_ready,
    output logic                  result_valid,
    output dar_pkg::result_t      result,
    output logic                  item_ready,
    output dar_pkg::cap_t         cap
);
    import dar_pkg::*;

    logic    s1_valid_reg;
    stage_t  s1_reg;
    logic    result_valid_reg;
    result_t result_reg;
    logic    s1_adv;
    result_t s1_result;

    assign s1_adv     = !result_valid_reg || result_ready;
    assign item_ready = !s1_valid_reg || s1_adv;

    // Result from the read stage, store byte where the item read one
    always_comb
    begin
        s1_result.read_data         = s1_reg.mem_rd ? rdata : s1_reg.read_data;
        s1_result.timer_irq         = s1_reg.timer_irq;
        s1_result.disk_irq          = s1_reg.disk_irq;
        s1_result.mirror_horizontal = s1_reg.mirror;
    end

    // File size capture fires once, as the item leaves the read stage
    assign cap.en   = s1_valid_reg && s1_adv && s1_reg.cap_en;
    assign cap.hi   = s1_reg.cap_hi;
    assign cap.data = rdata;

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                result_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
        if (s1_adv)
        begin
            result_reg <= s1_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `DAR_ASSERT_NXT(a_accept_fills, accept, s1_valid_reg, "accepted transaction not in read stage")
    `DAR_ASSERT_NXT(a_stage_holds, s1_valid_reg && !s1_adv,
                    s1_valid_reg && $stable(s1_reg), "stalled read stage changed")
    `DAR_ASSERT_IMP(a_ready_full, !item_ready, s1_valid_reg && result_valid_reg,
                    "input stalled with free stage")
    `DAR_ASSERT_IMP(a_cap_from_read, cap.en, s1_reg.mem_rd, "size capture without store read")

endmodule

`default_nettype wire

[rtl/disk_adapter_registers_top.sv]
// Top level of the disk adapter register block.
// Depends on dar_pkg, dar_store, dar_ctrl and dar_pipe.
//
// Channel  Direction  Handshake                    Payload
// item     in         item_valid / item_ready      item   (dar_pkg::item_t)
// result   out        result_valid / result_ready  result (dar_pkg::result_t)
//
// One transaction per cycle sustained while result_ready holds; each item gives one
// result via the read stage, holding the registered store read, and output register.
// Reset clears the state and valid registers; payloads and the byte store are not cleared.
// A waiting result does not block input: a new item enters while the read
// stage is free, and input stalls only when both read stage and output are full.
`default_nettype none

module disk_adapter_registers_top #(
    parameter int SIDE_BYTES = dar_pkg::SIDE_BYTES_DEF,
    parameter int SEEK_DELAY = dar_pkg::SEEK_DELAY_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire dar_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output dar_pkg::result_t      result
);
    import dar_pkg::*;

    logic     accept;
    stage_t   stage;
    mem_req_t req;
    cap_t     cap;
    logic [7:0] rdata;

    assign accept = item_valid && item_ready;

    // Register stage
    dar_ctrl #(
        .SIDE_BYTES (SIDE_BYTES),
        .SEEK_DELAY (SEEK_DELAY)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cap    (cap),
        .stage  (stage),
        .req    (req)
    );

    // Disk side byte store
    dar_store #(
        .SIDE_BYTES (SIDE_BYTES)
    ) u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // Read stage and output register
    dar_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .stage        (stage),
        .rdata        (rdata),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .item_ready   (item_ready),
        .cap          (cap)
    );

endmodule

`default_nettype wire
